// ----- hdl/rvex_pkg.sv -----
// Shared constants, operation codes and types for the RV32I execute block.
package rvex_pkg;

  localparam int XLEN      = 32;
  localparam int REG_COUNT = 32;
  localparam int REG_IDX_W = $clog2(REG_COUNT);
  localparam int OP_W      = 5;
  localparam int SHAMT_W   = $clog2(XLEN);

  localparam logic [XLEN-1:0] JALR_MASK = 32'hFFFF_FFFE;

  typedef enum logic [OP_W-1:0] {
    OP_OR     = 5'd0,
    OP_AND    = 5'd1,
    OP_XOR    = 5'd2,
    OP_ADD    = 5'd3,
    OP_SUB    = 5'd4,
    OP_SLL    = 5'd5,
    OP_SRL    = 5'd6,
    OP_SRA    = 5'd7,
    OP_SLT    = 5'd8,
    OP_SLTU   = 5'd9,
    OP_AUIPC  = 5'd10,
    OP_JAL    = 5'd11,
    OP_JALR   = 5'd12,
    OP_LSADDR = 5'd13,
    OP_BEQ    = 5'd14,
    OP_BNE    = 5'd15,
    OP_BLT    = 5'd16,
    OP_BLTU   = 5'd17,
    OP_BGE    = 5'd18,
    OP_BGEU   = 5'd19
  } op_t;

  // Register file write request
  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] index;
    logic [XLEN-1:0]      data;
  } rvex_wr_t;

endpackage

// ----- hdl/rv32i_execute_alu_regfile.sv -----
// Top level of the RV32I execute stage with its register file.
//
// Input channel (in_valid/in_ready): one decoded instruction per word, with
// operand indices, immediate, PC and an optional register writeback.
// Output channel (out_valid/out_ready): one 32-bit result word per input word.
//
// Operand reads go to the register file RAM at the accept edge; the same
// word's writeback is written at that edge, so it is seen by the next word
// and not by its own operands. Stage 1 holds the read data, the ALU result
// is then registered into the output register.
// out_valid rises once the word has passed from stage 1 into the output
// register; an output stall can hold it in stage 1 on the way.
// Throughput: one word per cycle while the output is not stalled, with the
// register file write and read ports taking one word at each accept.
// Reset clears the pipeline valids and the register file written flags, so
// every register reads zero afterwards; no clearing pass is needed.
// When out_ready is low the output register holds, stage 1 still fills, and
// in_ready drops only once both are occupied.
module rv32i_execute_alu_regfile
  import rvex_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      operation,
  input  logic [REG_IDX_W-1:0] src1_index,
  input  logic [REG_IDX_W-1:0] src2_index,
  input  logic [XLEN-1:0]      immediate,
  input  logic                 use_immediate,
  input  logic [XLEN-1:0]      pc,
  input  logic                 wb_enable,
  input  logic [REG_IDX_W-1:0] wb_index,
  input  logic [XLEN-1:0]      wb_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [XLEN-1:0]      result
);

  logic            accept;
  logic            s1_advance;
  logic            s1_valid;
  logic [OP_W-1:0] s1_op;
  logic [XLEN-1:0] s1_imm;
  logic            s1_use_imm;
  logic [XLEN-1:0] s1_pc;
  logic [XLEN-1:0] rs1_data;
  logic [XLEN-1:0] rs2_data;
  logic [XLEN-1:0] alu_result;
  rvex_wr_t        wr;

  assign accept     = in_valid && in_ready;
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  // Writeback applied at accept, after this word's reads are sampled
  assign wr.en    = accept && wb_enable;
  assign wr.index = wb_index;
  assign wr.data  = wb_data;

  rvex_regfile u_regfile (
    .clk   (clk),
    .rst   (rst),
    .re    (accept),
    .raddr1(src1_index),
    .raddr2(src2_index),
    .wr    (wr),
    .rdata1(rs1_data),
    .rdata2(rs2_data)
  );

  // Stage 1 control and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op      <= operation;
      s1_imm     <= immediate;
      s1_use_imm <= use_immediate;
      s1_pc      <= pc;
    end
  end

  rvex_alu u_alu (
    .op      (s1_op),
    .rs1_data(rs1_data),
    .rs2_data(rs2_data),
    .imm     (s1_imm),
    .use_imm (s1_use_imm),
    .pc      (s1_pc),
    .result  (alu_result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      result <= alu_result;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
      (s1_valid && !s1_advance) |-> !in_ready)
    else $error("input accepted over a stalled stage 1 word");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
      s1_advance |=> out_valid)
    else $error("stage 1 word lost on its way to the output register");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (rst)
      (s1_valid && out_valid && !out_ready) |=> s1_valid && $stable(s1_op))
    else $error("stage 1 word dropped during output stall");

endmodule

// ----- hdl/rvex_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rvex_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old word when the same entry is written in that cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/rvex_regfile.sv -----
// 32-entry register file: two RAM banks for two read ports, valid bits for reset.
module rvex_regfile
  import rvex_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 re,
  input  logic [REG_IDX_W-1:0] raddr1,
  input  logic [REG_IDX_W-1:0] raddr2,
  input  rvex_wr_t             wr,
  output logic [XLEN-1:0]      rdata1,
  output logic [XLEN-1:0]      rdata2
);

  logic                 we;
  logic [REG_COUNT-1:0] vld;
  logic                 vld1;
  logic                 vld2;
  logic [XLEN-1:0]      bank1_q;
  logic [XLEN-1:0]      bank2_q;

  // x0 is never written, so it stays invalid and reads zero
  assign we = wr.en && (wr.index != '0);

  rvex_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_bank1 (
    .clk  (clk),
    .we   (we),
    .waddr(wr.index),
    .wdata(wr.data),
    .re   (re),
    .raddr(raddr1),
    .rdata(bank1_q)
  );

  rvex_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_bank2 (
    .clk  (clk),
    .we   (we),
    .waddr(wr.index),
    .wdata(wr.data),
    .re   (re),
    .raddr(raddr2),
    .rdata(bank2_q)
  );

  // Per-entry written flags; cleared at reset so entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[wr.index] <= 1'b1;
    end
  end

  // Flags sampled alongside the RAM read, old value on same-cycle write
  always_ff @(posedge clk) begin
    if (re) begin
      vld1 <= vld[raddr1];
      vld2 <= vld[raddr2];
    end
  end

  assign rdata1 = vld1 ? bank1_q : '0;
  assign rdata2 = vld2 ? bank2_q : '0;

  a_x0_never_valid: assert property (@(posedge clk) disable iff (rst) !vld[0])
    else $error("x0 marked as written");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (rst)
      we |=> vld[$past(wr.index)])
    else $error("written entry not marked valid");

endmodule

// ----- hdl/rvex_alu.sv -----
// Operand select, ALU, PC-relative add and branch compare.
module rvex_alu
  import rvex_pkg::*;
(
  input  logic [OP_W-1:0] op,
  input  logic [XLEN-1:0] rs1_data,
  input  logic [XLEN-1:0] rs2_data,
  input  logic [XLEN-1:0] imm,
  input  logic            use_imm,
  input  logic [XLEN-1:0] pc,
  output logic [XLEN-1:0] result
);

  logic                is_branch;
  logic [XLEN-1:0]     a;
  logic [XLEN-1:0]     b;
  logic [SHAMT_W-1:0]  sh;
  logic [XLEN-1:0]     sum;
  logic                lt_s;
  logic                lt_u;

  // Branches always compare two registers
  assign is_branch = (op >= OP_BEQ) && (op <= OP_BGEU);
  assign a    = rs1_data;
  assign b    = (use_imm && !is_branch) ? imm : rs2_data;
  assign sh   = b[SHAMT_W-1:0];
  assign sum  = a + b;
  assign lt_s = $signed(a) < $signed(b);
  assign lt_u = a < b;

  always_comb begin
    case (op_t'(op))
      OP_OR:     result = a | b;
      OP_AND:    result = a & b;
      OP_XOR:    result = a ^ b;
      OP_ADD:    result = sum;
      OP_SUB:    result = a - b;
      OP_SLL:    result = a << sh;
      OP_SRL:    result = a >> sh;
      OP_SRA:    result = XLEN'($signed(a) >>> sh);
      OP_SLT:    result = {{(XLEN-1){1'b0}}, lt_s};
      OP_SLTU:   result = {{(XLEN-1){1'b0}}, lt_u};
      OP_AUIPC:  result = pc + b;
      OP_JAL:    result = pc + b;
      OP_JALR:   result = sum & JALR_MASK;
      OP_LSADDR: result = sum;
      OP_BEQ:    result = {{(XLEN-1){1'b0}}, (a == b)};
      OP_BNE:    result = {{(XLEN-1){1'b0}}, (a != b)};
      OP_BLT:    result = {{(XLEN-1){1'b0}}, lt_s};
      OP_BLTU:   result = {{(XLEN-1){1'b0}}, lt_u};
      OP_BGE:    result = {{(XLEN-1){1'b0}}, !lt_s};
      OP_BGEU:   result = {{(XLEN-1){1'b0}}, !lt_u};
      default:   result = '0;
    endcase
  end

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the RV32I execute stage and its register file.
module tb;
  import rvex_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 40;

  // One instruction word as offered on the input channel
  typedef struct {
    logic [OP_W-1:0]      operation;
    logic [REG_IDX_W-1:0] src1_index;
    logic [REG_IDX_W-1:0] src2_index;
    logic [XLEN-1:0]      immediate;
    logic                 use_immediate;
    logic [XLEN-1:0]      pc;
    logic                 wb_enable;
    logic [REG_IDX_W-1:0] wb_index;
    logic [XLEN-1:0]      wb_data;
  } instr_word_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [OP_W-1:0]      operation;
  logic [REG_IDX_W-1:0] src1_index;
  logic [REG_IDX_W-1:0] src2_index;
  logic [XLEN-1:0]      immediate;
  logic                 use_immediate;
  logic [XLEN-1:0]      pc;
  logic                 wb_enable;
  logic [REG_IDX_W-1:0] wb_index;
  logic [XLEN-1:0]      wb_data;
  logic                 out_valid;
  logic                 out_ready;
  logic [XLEN-1:0]      result;

  // Shadow register file and results still owed by the block
  logic [XLEN-1:0] reg_shadow [REG_COUNT];
  logic [XLEN-1:0] pending_results [$];
  int              op_hits [32];

  int words_in;
  int results_out;
  int mismatches;
  int idle_cycles;
  int hold_left;
  bit rx_stall_mode;

  // Operand selection scratch for the accept monitor
  logic            is_branch;
  logic [XLEN-1:0] op_a;
  logic [XLEN-1:0] op_b;
  logic [XLEN-1:0] want;

  rv32i_execute_alu_regfile DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .src1_index    (src1_index),
    .src2_index    (src2_index),
    .immediate     (immediate),
    .use_immediate (use_immediate),
    .pc            (pc),
    .wb_enable     (wb_enable),
    .wb_index      (wb_index),
    .wb_data       (wb_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result        (result)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ALU / branch / address result for one instruction
  function automatic logic [XLEN-1:0] execute_op(input logic [OP_W-1:0] op,
                                                 input logic [XLEN-1:0] a,
                                                 input logic [XLEN-1:0] b,
                                                 input logic [XLEN-1:0] pc_val);
    logic [SHAMT_W-1:0] sh;
    logic [XLEN-1:0]    r;
    sh = b[SHAMT_W-1:0];
    r  = '0;
    case (op_t'(op))
      OP_OR:            r = a | b;
      OP_AND:           r = a & b;
      OP_XOR:           r = a ^ b;
      OP_ADD, OP_LSADDR: r = a + b;
      OP_SUB:           r = a - b;
      OP_SLL:           r = a << sh;
      OP_SRL:           r = a >> sh;
      OP_SRA:           r = $signed(a) >>> sh;
      OP_SLT, OP_BLT:   r[0] = $signed(a) < $signed(b);
      OP_SLTU, OP_BLTU: r[0] = a < b;
      OP_AUIPC, OP_JAL: r = pc_val + b;
      OP_JALR:          r = (a + b) & JALR_MASK;
      OP_BEQ:           r[0] = a == b;
      OP_BNE:           r[0] = a != b;
      OP_BGE:           r[0] = !($signed(a) < $signed(b));
      OP_BGEU:          r[0] = a >= b;
      default:          r = '0;
    endcase
    return r;
  endfunction

  // Corner values, sign-extended short immediates, small shift counts or random words
  function automatic logic [XLEN-1:0] pick_value();
    logic [11:0] low;
    low = 12'($urandom());
    case ($urandom_range(0, 4))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 32'h0000_0000;
          1:       return 32'h0000_0001;
          2:       return 32'h7FFF_FFFF;
          3:       return 32'h8000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1:       return {{20{low[11]}}, low};
      2:       return XLEN'($urandom_range(0, 40));
      default: return $urandom();
    endcase
  endfunction

  function automatic instr_word_t random_word();
    instr_word_t w;
    if ($urandom_range(0, 9) == 0)
      w.operation = OP_W'($urandom_range(20, 31));
    else
      w.operation = OP_W'($urandom_range(0, 19));
    w.src1_index    = REG_IDX_W'($urandom_range(0, 31));
    w.src2_index    = ($urandom_range(0, 3) == 0) ? w.src1_index
                                                  : REG_IDX_W'($urandom_range(0, 31));
    w.immediate     = pick_value();
    w.use_immediate = 1'($urandom_range(0, 1));
    w.pc            = $urandom();
    w.wb_enable     = ($urandom_range(0, 3) != 0);
    w.wb_index      = REG_IDX_W'($urandom_range(0, 31));
    w.wb_data       = pick_value();
    return w;
  endfunction

  // Accept monitor: predict the result and apply the writeback after the reads
  always @(posedge clk) begin
    if (rst) begin
      foreach (reg_shadow[i]) reg_shadow[i] = '0;
    end else if (in_valid && in_ready) begin
      is_branch = (operation >= OP_BEQ) && (operation <= OP_BGEU);
      op_a      = reg_shadow[src1_index];
      op_b      = (use_immediate && !is_branch) ? immediate : reg_shadow[src2_index];
      pending_results.push_back(execute_op(operation, op_a, op_b, pc));
      if (wb_enable && wb_index != 0)
        reg_shadow[wb_index] = wb_data;
      op_hits[operation]++;
      words_in++;
    end
  end

  task automatic report_mismatch(input string what, input logic [XLEN-1:0] got,
                                 input logic [XLEN-1:0] exp_val);
    $display("mismatch at result %0d: %s, got %h want %h", results_out, what, got, exp_val);
    mismatches++;
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing pending", result, '0);
      end else begin
        want = pending_results.pop_front();
        if (result !== want)
          report_mismatch("result", result, want);
      end
      results_out++;
    end
  end

  // Receiver: long hold when asked, else random stalls or always ready
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (rx_stall_mode) begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results pending",
               IDLE_LIMIT, pending_results.size());
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one word at the current falling edge and hold it until accepted
  task automatic send_word(input instr_word_t w);
    int target;
    target = words_in + 1;
    in_valid      <= 1'b1;
    operation     <= w.operation;
    src1_index    <= w.src1_index;
    src2_index    <= w.src2_index;
    immediate     <= w.immediate;
    use_immediate <= w.use_immediate;
    pc            <= w.pc;
    wb_enable     <= w.wb_enable;
    wb_index      <= w.wb_index;
    wb_data       <= w.wb_data;
    do @(negedge clk); while (words_in < target);
  endtask

  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Corner operands, every defined operation code, x0 writes and same-word writeback
  task automatic test_directed();
    instr_word_t w;
    logic [XLEN-1:0] preload [3];
    preload = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0025};
    rx_stall_mode = 1'b1;
    for (int i = 0; i < 3; i++) begin
      w = '{default: '0};
      w.operation = OP_ADD;
      w.wb_enable = 1'b1;
      w.wb_index  = REG_IDX_W'(i + 1);
      w.wb_data   = preload[i];
      send_word(w);
      idle_gap($urandom_range(0, 2));
    end
    // write to x0 must not stick
    w = '{default: '0};
    w.operation = OP_OR;
    w.wb_enable = 1'b1;
    w.wb_data   = 32'hDEAD_BEEF;
    send_word(w);
    // all defined codes plus two unused ones; writeback targets its own source
    for (int i = 0; i < 22; i++) begin
      w.operation     = (i < 20) ? OP_W'(i) : ((i == 20) ? OP_W'(20) : OP_W'(31));
      w.src1_index    = REG_IDX_W'(i % 4);
      w.src2_index    = REG_IDX_W'((i + 1) % 4);
      w.use_immediate = 1'(i % 2);
      w.immediate     = ((i / 2) % 2) ? 32'hFFFF_FFFF : 32'h0000_0025;
      w.pc            = 32'hFFFF_FFF8;
      w.wb_enable     = 1'b1;
      w.wb_index      = REG_IDX_W'(i % 4);
      w.wb_data       = ((i / 4) % 2) ? 32'h7FFF_FFFF : 32'h8000_0001;
      send_word(w);
      idle_gap($urandom_range(0, 2));
    end
  endtask

  // Back-to-back words with the receiver always ready
  task automatic test_full_rate(input int count);
    rx_stall_mode = 1'b0;
    repeat (count) send_word(random_word());
  endtask

  // Receiver holds off while the sender keeps offering, filling the pipeline
  task automatic test_back_pressure(input int count);
    rx_stall_mode = 1'b0;
    hold_left     = HOLD_CYCLES;
    repeat (count) send_word(random_word());
  endtask

  // Random bursts and gaps against a stalling receiver
  task automatic test_random_stream(input int count);
    int sent;
    int burst;
    sent          = 0;
    rx_stall_mode = 1'b1;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < count; k++) begin
        send_word(random_word());
        sent++;
      end
      if ($urandom_range(0, 3) != 0)
        idle_gap($urandom_range(1, 5));
    end
  endtask

  initial begin
    int ops_seen;
    rst           = 1'b1;
    in_valid      = 1'b0;
    operation     = '0;
    src1_index    = '0;
    src2_index    = '0;
    immediate     = '0;
    use_immediate = 1'b0;
    pc            = '0;
    wb_enable     = 1'b0;
    wb_index      = '0;
    wb_data       = '0;
    words_in      = 0;
    results_out   = 0;
    mismatches    = 0;
    idle_cycles   = 0;
    hold_left     = 0;
    rx_stall_mode = 1'b0;
    ops_seen      = 0;
    foreach (op_hits[i]) op_hits[i] = 0;
    foreach (reg_shadow[i]) reg_shadow[i] = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_rate(30);
    test_back_pressure(20);
    test_random_stream(330);

    // drain outstanding results, then allow for stray words
    idle_gap(1);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    foreach (op_hits[i]) if (op_hits[i] != 0) ops_seen++;
    $display("run: %0d instruction words in, %0d result words checked, %0d mismatches",
             words_in, results_out, mismatches);
    $display("run: %0d of 32 operation codes exercised, incl. full rate, a %0d-cycle hold",
             ops_seen, HOLD_CYCLES);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
